// ===== sv/sign_magnitude_accumulator_unit_defines.svh =====
// Assertion macros for the sign-magnitude accumulator unit checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SIGN_MAGNITUDE_ACCUMULATOR_UNIT_DEFINES_SVH
`define SIGN_MAGNITUDE_ACCUMULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SMA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sma assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sma assertion failed");

// Next-cycle implication that also holds across reset.
`define SMA_ASSERT_RESET(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sma reset assertion failed");

`endif

// ===== sv/sma_pkg.sv =====
// Shared types and constants for the sign-magnitude accumulator unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sma_pkg;

    localparam int DEF_WORD_BITS = 20;
    localparam int DEF_NUM_REGS  = 4;

    localparam int FUNC_BITS    = 3;
    localparam int OPERAND_BITS = 20;
    localparam int SEL_BITS     = 2;
    localparam int OUT_WORD_BITS = 20;
    localparam int COUNT_BITS   = 16;

    // Input beat layout
    localparam int IN_TDATA_BITS = ((OPERAND_BITS + 7) / 8) * 8;
    localparam int IN_TUSER_BITS = FUNC_BITS + SEL_BITS;

    // Output beat layout: acc_bits, sign_flag, reg_value, overflow, instr_count
    localparam int OUT_ACC_LSB   = 0;
    localparam int OUT_SIGN_BIT  = OUT_ACC_LSB + OUT_WORD_BITS;
    localparam int OUT_REG_LSB   = OUT_SIGN_BIT + 1;
    localparam int OUT_OVF_BIT   = OUT_REG_LSB + OUT_WORD_BITS;
    localparam int OUT_CNT_LSB   = OUT_OVF_BIT + 1;
    localparam int OUT_FIELD_BITS = OUT_CNT_LSB + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 4;

    // Reciprocal scaling for the rotate amount reduction
    localparam int RECIP_SHIFT = OPERAND_BITS + 7;

    // Opcodes as they arrive on the bus
    localparam logic [FUNC_BITS-1:0] FUNC_MOV  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ADD  = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_ROTL = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_ROTR = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_SAVE = 3'd4;

    // Decoded operation handed from front to back
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_ADD,
        OP_ROT,
        OP_SAVE,
        OP_NOP
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// ===== sv/sma_queue.sv =====
// Small FIFO between the decode front and the execute back.
// Depends on sma_pkg for the status struct.
`default_nettype none

module sma_queue
    import sma_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output t_queue_status         o_status
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_slot [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == CNT_BITS'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sma_front.sv =====
// Decode front: takes input beats, converts the operand to sign-magnitude
// and reduces rotate amounts. Depends on sma_pkg.
`default_nettype none

module sma_front
    import sma_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int AMT_BITS = $clog2(WORD_BITS),
    localparam int CMD_BITS = $bits(t_op) + AMT_BITS + SEL_BITS + WORD_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [FUNC_BITS-1:0]    i_func,
    input  wire logic [OPERAND_BITS-1:0] i_operand,
    input  wire logic [SEL_BITS-1:0]     i_sel,
    input  wire t_queue_status           i_q_status,
    output logic                         o_push,
    output logic [CMD_BITS-1:0]          o_cmd
);

    typedef struct packed {
        t_op                  op;
        logic [AMT_BITS-1:0]  amt;
        logic [SEL_BITS-1:0]  sel;
        logic [WORD_BITS-1:0] smag;
    } t_cmd;

    localparam int MAG_BITS    = WORD_BITS - 1;
    localparam int RECIP_BITS  = RECIP_SHIFT - 1;
    localparam int PROD_BITS   = OPERAND_BITS + RECIP_BITS;
    localparam int Q_BITS      = PROD_BITS - RECIP_SHIFT;
    localparam int REM_BITS    = Q_BITS + 8;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);
    localparam logic [63:0] MAG_MAX = {64{1'b1}} >> (65 - WORD_BITS);

    // stage A registers
    logic                    r_a_valid;
    t_op                     r_a_op;
    logic                    r_a_rotr;
    logic [SEL_BITS-1:0]     r_a_sel;
    logic [WORD_BITS-1:0]    r_a_smag;
    logic [OPERAND_BITS-1:0] r_a_raw;
    logic [Q_BITS-1:0]       r_a_q;

    t_op                     n_op;
    logic [OPERAND_BITS-1:0] mag_raw;
    logic [63:0]             mag_sat;
    logic [WORD_BITS-1:0]    n_smag;
    logic [PROD_BITS-1:0]    prod;
    logic                    accept;

    logic [REM_BITS-1:0]     rem_full;
    logic [REM_BITS-1:0]     rem_fix;
    logic [AMT_BITS-1:0]     amt_l;
    logic [AMT_BITS:0]       amt_r;
    t_cmd                    cmd;

    assign o_ready = !r_a_valid || !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_a_valid && !i_q_status.full;

    always_comb begin
        case (i_func)
            FUNC_MOV:  n_op = OP_LOAD;
            FUNC_ADD:  n_op = OP_ADD;
            FUNC_ROTL: n_op = OP_ROT;
            FUNC_ROTR: n_op = OP_ROT;
            FUNC_SAVE: n_op = OP_SAVE;
            default:   n_op = OP_NOP;
        endcase
    end

    // two's complement to sign-magnitude; a magnitude too large saturates
    always_comb begin
        mag_raw = i_operand[OPERAND_BITS-1] ? (~i_operand + 1'b1) : i_operand;
        mag_sat = (64'(mag_raw) > MAG_MAX) ? MAG_MAX : 64'(mag_raw);
        n_smag  = {i_operand[OPERAND_BITS-1], mag_sat[MAG_BITS-1:0]};
    end

    // quotient estimate of operand / WORD_BITS
    assign prod = PROD_BITS'(i_operand) * PROD_BITS'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_op   <= n_op;
            r_a_rotr <= (i_func == FUNC_ROTR);
            r_a_sel  <= i_sel;
            r_a_smag <= n_smag;
            r_a_raw  <= i_operand;
            r_a_q    <= prod[PROD_BITS-1:RECIP_SHIFT];
        end
    end

    // remainder and right-rotate as a left-rotate amount
    always_comb begin
        rem_full = REM_BITS'(r_a_raw) - REM_BITS'(r_a_q) * REM_BITS'(WORD_BITS);
        rem_fix  = (rem_full >= REM_BITS'(WORD_BITS)) ?
                   rem_full - REM_BITS'(WORD_BITS) : rem_full;
        amt_l    = rem_fix[AMT_BITS-1:0];
        amt_r    = (AMT_BITS+1)'(WORD_BITS) - {1'b0, amt_l};
        cmd.op   = r_a_op;
        cmd.amt  = !r_a_rotr ? amt_l : ((amt_l == '0) ? '0 : amt_r[AMT_BITS-1:0]);
        cmd.sel  = r_a_sel;
        cmd.smag = r_a_smag;
    end

    assign o_cmd = cmd;

endmodule

`default_nettype wire

// ===== sv/sma_back.sv =====
// Execute back: accumulator, register file and counter. Depends on sma_pkg.
// Carries out one command per cycle into an output register unless stalled.
`default_nettype none

module sma_back
    import sma_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int NUM_REGS  = DEF_NUM_REGS,
    localparam int AMT_BITS = $clog2(WORD_BITS),
    localparam int CMD_BITS = $bits(t_op) + AMT_BITS + SEL_BITS + WORD_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_queue_status             i_q_status,
    input  wire logic [CMD_BITS-1:0]       i_cmd,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [OUT_TDATA_BITS-1:0]      o_data
);

    typedef struct packed {
        t_op                  op;
        logic [AMT_BITS-1:0]  amt;
        logic [SEL_BITS-1:0]  sel;
        logic [WORD_BITS-1:0] smag;
    } t_cmd;

    localparam int MAG_BITS = WORD_BITS - 1;

    logic [WORD_BITS-1:0]  r_acc;
    logic [WORD_BITS-1:0]  r_regs [NUM_REGS];
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;

    t_cmd                  cmd;
    logic [WORD_BITS-1:0]  n_acc;
    logic [COUNT_BITS-1:0] n_count;
    logic                  ovf;
    logic                  sa;
    logic                  sb;
    logic [MAG_BITS-1:0]   ma;
    logic [MAG_BITS-1:0]   mb;
    logic [MAG_BITS:0]     sum;
    logic [2*WORD_BITS-1:0] dbl;
    logic                  sel_ok;
    logic [WORD_BITS-1:0]  reg_rd;
    logic [WORD_BITS-1:0]  n_reg_val;
    logic [63:0]           acc_wide;
    logic [63:0]           reg_wide;

    assign cmd     = i_cmd;
    assign o_pop   = !i_q_status.empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    assign sa  = r_acc[WORD_BITS-1];
    assign sb  = cmd.smag[WORD_BITS-1];
    assign ma  = r_acc[MAG_BITS-1:0];
    assign mb  = cmd.smag[MAG_BITS-1:0];
    assign sum = {1'b0, ma} + {1'b0, mb};
    assign dbl = {r_acc, r_acc} << cmd.amt;

    always_comb begin
        n_acc = r_acc;
        ovf   = 1'b0;
        case (cmd.op)
            OP_LOAD: n_acc = cmd.smag;
            OP_ADD: begin
                if (sa == sb) begin
                    // magnitude wraps, sign kept
                    n_acc = {sa, sum[MAG_BITS-1:0]};
                    ovf   = sum[MAG_BITS];
                end else if (ma > mb) begin
                    n_acc = {sa, ma - mb};
                end else if (mb > ma) begin
                    n_acc = {sb, mb - ma};
                end else begin
                    n_acc = '0;
                end
            end
            OP_ROT:  n_acc = dbl[2*WORD_BITS-1:WORD_BITS];
            default: n_acc = r_acc;
        endcase
        n_count = (cmd.op == OP_NOP) ? r_count : r_count + 1'b1;
    end

    always_comb begin
        sel_ok = (int'(cmd.sel) < NUM_REGS);
        reg_rd = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (int'(cmd.sel) == i) begin
                reg_rd = r_regs[i];
            end
        end
        if (!sel_ok) begin
            n_reg_val = '0;
        end else if (cmd.op == OP_SAVE) begin
            n_reg_val = r_acc;
        end else begin
            n_reg_val = reg_rd;
        end
        acc_wide = 64'(n_acc);
        reg_wide = 64'(n_reg_val);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (o_pop) begin
                r_acc       <= n_acc;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (cmd.op == OP_SAVE && int'(cmd.sel) == i) begin
                        r_regs[i] <= r_acc;
                    end
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0),
                           n_count,
                           ovf,
                           reg_wide[OUT_WORD_BITS-1:0],
                           n_acc[WORD_BITS-1],
                           acc_wide[OUT_WORD_BITS-1:0]};
        end
    end

endmodule

`default_nettype wire

// ===== sv/sign_magnitude_accumulator_unit.sv =====
// Top level of the sign-magnitude accumulator unit: decode front, command
// queue and execute back. Depends on sma_pkg, sma_front, sma_queue, sma_back.
//
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------
// s_axis   | in  | s_axis_tvalid/tready    | tdata: operand_value; tuser: func,
//          |     |                         |        reg_select
// m_axis   | out | m_axis_tvalid/tready    | tdata: acc_bits, sign_flag,
//          |     |                         |        reg_value, overflow, instr_count
//
// One beat per cycle in both directions while neither side stalls; the execute
// back retires one command per cycle from the queue while it is not empty and
// its output register is free or being taken, set by its single accumulator
// update loop. Beat path: decode register, queue slot, output register.
// Reset is synchronous and active low; state clears at once, no sweep.
// A stalled m_axis fills the QUEUE_DEPTH-entry queue and the decode register,
// after which s_axis_tready drops; neither side waits on the other otherwise.
`default_nettype none

module sign_magnitude_accumulator_unit
    import sma_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,   // accumulator width, 4..64
    parameter int NUM_REGS  = DEF_NUM_REGS     // register file depth, 1..4
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input beats
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [19:0] operand_value (signed), [23:20] zero
    input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
    // [2:0] func, [4:3] reg_select
    input  wire logic [IN_TUSER_BITS-1:0]  s_axis_tuser,
    // result beats
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [19:0] acc_bits, [20] sign_flag, [40:21] reg_value, [41] overflow,
    // [57:42] instr_count, [63:58] zero
    output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata
);

    localparam int AMT_BITS = $clog2(WORD_BITS);
    localparam int CMD_BITS = $bits(t_op) + AMT_BITS + SEL_BITS + WORD_BITS;

    logic                push;
    logic                pop;
    logic [CMD_BITS-1:0] cmd_in;
    logic [CMD_BITS-1:0] cmd_out;
    t_queue_status       q_status;

    // decode: opcode class, sign-magnitude operand, reduced rotate amount
    sma_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_func     (s_axis_tuser[FUNC_BITS-1:0]),
        .i_operand  (s_axis_tdata[OPERAND_BITS-1:0]),
        .i_sel      (s_axis_tuser[FUNC_BITS +: SEL_BITS]),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (cmd_in)
    );

    // decoupling queue between decode and execute
    sma_queue #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (cmd_in),
        .i_pop    (pop),
        .o_data   (cmd_out),
        .o_status (q_status)
    );

    // execute: accumulator, registers, counter and the output register
    sma_back #(
        .WORD_BITS (WORD_BITS),
        .NUM_REGS  (NUM_REGS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== sv/sma_checker.sv =====
// Port-level checker for the sign-magnitude accumulator unit and its bind.
// Depends on sma_pkg and sign_magnitude_accumulator_unit_defines.svh.
`default_nettype none
`include "sign_magnitude_accumulator_unit_defines.svh"

module sma_checker
    import sma_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);

    logic                  r_seen;
    logic [COUNT_BITS-1:0] r_last_cnt;
    logic [COUNT_BITS-1:0] cnt;
    logic                  out_beat;
    logic                  word20;

    assign cnt      = m_axis_tdata[OUT_CNT_LSB +: COUNT_BITS];
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign word20   = (WORD_BITS == OUT_WORD_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_cnt <= '0;
        end else if (out_beat) begin
            r_seen     <= 1'b1;
            r_last_cnt <= cnt;
        end
    end

    // a held result keeps its payload
    `SMA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // reset leaves no result pending and the input side open
    `SMA_ASSERT_RESET(a_reset, i_clk, !i_rst_n, !m_axis_tvalid && s_axis_tready)
    // counter advances by at most one between results
    `SMA_ASSERT_SAME(a_count_step, i_clk, i_rst_n, m_axis_tvalid && r_seen, cnt == r_last_cnt || cnt == COUNT_BITS'(r_last_cnt + 1'b1))
    // an overflowing add is always counted
    `SMA_ASSERT_SAME(a_ovf_counted, i_clk, i_rst_n, m_axis_tvalid && r_seen && m_axis_tdata[OUT_OVF_BIT], cnt == COUNT_BITS'(r_last_cnt + 1'b1))
    // at the native width the sign flag mirrors the top accumulator bit
    `SMA_ASSERT_SAME(a_sign_bit, i_clk, i_rst_n, m_axis_tvalid && word20, m_axis_tdata[OUT_SIGN_BIT] == m_axis_tdata[OUT_WORD_BITS-1])

endmodule

bind sign_magnitude_accumulator_unit sma_checker #(
    .WORD_BITS (WORD_BITS)
) u_sma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
